@@ hw/rtl/pln_pkg.sv @@
// ----------------------------------------------------------------------------
// pln_pkg : shared types and helpers for the periodic lattice neighbor index
// Site and extent widths, the saturating span type and the per-beat context
// carried through the remainder pipeline.
// ----------------------------------------------------------------------------
package pln_pkg;

    localparam int NUM_AXES  = 4;
    localparam int SITE_BITS = 24;
    localparam int EXT_BITS  = 13;
    localparam int AXIS_BITS = 2;
    localparam int DIR_BITS  = 3;
    localparam int SPAN_IDX_BITS = 3;   // indexes NUM_AXES + 1 spans

    localparam logic [EXT_BITS-1:0] EXT_RESET = EXT_BITS'(8);

    // Product of extents kept as its low SITE_BITS bits plus a flag that is set
    // when the true value reaches 2^SITE_BITS.
    typedef struct packed {
        logic                 big;
        logic [SITE_BITS-1:0] low;
    } t_span;

    typedef struct packed {
        logic [SITE_BITS-1:0] site;
        logic                 backward;
        logic                 oor;
        t_span                stride;   // stride of the stepped axis
        t_span                wrap;     // (extent - 1) * stride
    } t_ctx;

    // Extent register with zero read as one.
    function automatic logic [EXT_BITS-1:0] eff_extent(logic [EXT_BITS-1:0] e);
        return (e == '0) ? EXT_BITS'(1) : e;
    endfunction

    // Multiply a span by a factor, keeping the low bits exact and saturating
    // the flag.
    function automatic t_span span_scale(t_span s, logic [EXT_BITS-1:0] f);
        logic [SITE_BITS+EXT_BITS-1:0] prod;
        t_span                         r;
        prod  = {{EXT_BITS{1'b0}}, s.low} * {{SITE_BITS{1'b0}}, f};
        r.big = (s.big && (f != '0)) || (prod[SITE_BITS+EXT_BITS-1:SITE_BITS] != '0);
        r.low = prod[SITE_BITS-1:0];
        return r;
    endfunction

    // Span as a value clamped to 2^SITE_BITS.
    function automatic logic [SITE_BITS:0] span_clamp(t_span s);
        return s.big ? {1'b1, {SITE_BITS{1'b0}}} : {1'b0, s.low};
    endfunction

endpackage

@@ hw/rtl/pln_rem_pipe.sv @@
// ----------------------------------------------------------------------------
// pln_rem_pipe : pipelined remainder of the site index by a span
// One restoring step per stage, most significant site bit first; the context
// of each beat travels alongside. Bubbles collapse on a stall.
// ----------------------------------------------------------------------------
module pln_rem_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pln_pkg::t_ctx                 i_ctx,
    input  logic [pln_pkg::SITE_BITS:0]   i_modulus,
    output logic                          o_valid,
    input  logic                          i_ready,
    output pln_pkg::t_ctx                 o_ctx,
    output logic [pln_pkg::SITE_BITS-1:0] o_rem
);

    localparam int N = pln_pkg::SITE_BITS;

    logic                   r_v   [N];
    pln_pkg::t_ctx          r_ctx [N];
    logic [N:0]             r_mod [N];
    logic [N-1:0]           r_rem [N];
    logic                   w_en  [N];

    logic                   w_src_v   [N];
    pln_pkg::t_ctx          w_src_ctx [N];
    logic [N:0]             w_src_mod [N];
    logic [N-1:0]           w_src_rem [N];

    // Stage k may load when it is empty or its content moves on.
    always_comb begin
        w_en[N-1] = !r_v[N-1] || i_ready;
        for (int k = N - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N:0] w_shift;

        if (k == 0) begin : g_first
            assign w_src_v[k]   = i_valid;
            assign w_src_ctx[k] = i_ctx;
            assign w_src_mod[k] = i_modulus;
            assign w_src_rem[k] = '0;
        end else begin : g_next
            assign w_src_v[k]   = r_v[k-1];
            assign w_src_ctx[k] = r_ctx[k-1];
            assign w_src_mod[k] = r_mod[k-1];
            assign w_src_rem[k] = r_rem[k-1];
        end

        // Bring in the next site bit, subtract the modulus if it fits.
        assign w_shift = {w_src_rem[k], w_src_ctx[k].site[N-1-k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_src_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_ctx[k] <= w_src_ctx[k];
                r_mod[k] <= w_src_mod[k];
                if (w_shift >= w_src_mod[k]) begin
                    r_rem[k] <= N'(w_shift - w_src_mod[k]);
                end else begin
                    r_rem[k] <= w_shift[N-1:0];
                end
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[N-1];
    assign o_ctx   = r_ctx[N-1];
    assign o_rem   = r_rem[N-1];

    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[N-1] |-> ({1'b0, r_rem[N-1]} < r_mod[N-1]))
        else $error("remainder not below modulus");

    a_mod_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> (r_mod[0] != '0))
        else $error("zero modulus entered the pipeline");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v[0])
        else $error("ready dropped with an empty first stage");

endmodule

@@ hw/rtl/periodic_lattice_neighbor_index_top.sv @@
// ----------------------------------------------------------------------------
// periodic_lattice_neighbor_index_top : neighbor site on a 4-D periodic lattice
// Steps one mixed-radix coordinate of a linear site index forward or backward
// with wrap-around and answers the new linear index.
// ----------------------------------------------------------------------------
//
//   channel   signals                                        direction
//   -------   --------------------------------------------   ---------
//   query     i_valid / o_ready, i_site_index, i_direction   in
//   result    o_valid / i_ready, o_neighbor_site,            out
//             o_out_of_range
//   config    i_cfg_we, i_cfg_index, i_cfg_data              in, no wait
//
// One beat enters per cycle while the result port is not stalled; the path
// holds five front stages, one stage per site bit (24) in the remainder
// pipeline, and the output register. The remainder pipeline is the longest
// part of the path; every stage takes a beat per cycle when it may load.
// Reset (synchronous, active low) empties every stage and sets all extents to 8.
// A stall at the result port holds the full stages; empty stages keep filling,
// so queries are taken until every stage holds a beat.
//
// Method: with stride s = product of the extents below the stepped axis and
// M = s * extent, the coordinate is zero when (site mod M) < s and is at its
// top when (site mod M) >= M - s. The neighbor is then site +/- s, or the
// wrap by (extent - 1) * s. Only site mod M needs a long iteration.
// ----------------------------------------------------------------------------
module periodic_lattice_neighbor_index_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [pln_pkg::SITE_BITS-1:0]      i_site_index,
    input  logic [pln_pkg::DIR_BITS-1:0]       i_direction,

    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [pln_pkg::SITE_BITS-1:0]      o_neighbor_site,
    output logic                               o_out_of_range,

    input  logic                               i_cfg_we,
    input  logic [pln_pkg::AXIS_BITS-1:0]      i_cfg_index,
    input  logic [pln_pkg::EXT_BITS-1:0]       i_cfg_data
);

    localparam int SB = pln_pkg::SITE_BITS;
    localparam int EB = pln_pkg::EXT_BITS;
    localparam int NA = pln_pkg::NUM_AXES;

    // ---------------------------------------------------------------- config
    logic [EB-1:0] r_ext [NA];
    logic [EB-1:0] w_eff [NA];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_ext[a] <= pln_pkg::EXT_RESET;
            end
        end else if (i_cfg_we) begin
            r_ext[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        for (int a = 0; a < NA; a++) begin
            w_eff[a] = pln_pkg::eff_extent(r_ext[a]);
        end
    end

    // ---------------------------------------------------------- front stages
    // F0 holds the accepted beat; F1..F3 build the stride spans one multiply
    // per stage; F4 picks the axis and forms the wrap distance, modulus and range flag.
    logic                           r_f0_v, r_f1_v, r_f2_v, r_f3_v, r_f4_v;
    logic [SB-1:0]                  r_f0_site, r_f1_site, r_f2_site, r_f3_site;
    logic [pln_pkg::DIR_BITS-1:0]   r_f0_dir, r_f1_dir, r_f2_dir, r_f3_dir;
    pln_pkg::t_span                 r_f1_span2, r_f2_span2, r_f3_span2;
    pln_pkg::t_span                 r_f2_span3, r_f3_span3;
    pln_pkg::t_span                 r_f3_span4;
    pln_pkg::t_ctx                  r_f4_ctx;
    logic [SB:0]                    r_f4_mod;

    logic w_en_f0, w_en_f1, w_en_f2, w_en_f3, w_en_f4;
    logic w_rem_ready;

    assign w_en_f4 = !r_f4_v || w_rem_ready;
    assign w_en_f3 = !r_f3_v || w_en_f4;
    assign w_en_f2 = !r_f2_v || w_en_f3;
    assign w_en_f1 = !r_f1_v || w_en_f2;
    assign w_en_f0 = !r_f0_v || w_en_f1;
    assign o_ready = w_en_f0;

    pln_pkg::t_span w_span1;
    pln_pkg::t_span w_span [NA+1];
    logic [pln_pkg::AXIS_BITS-1:0]     w_axis;
    logic [pln_pkg::SPAN_IDX_BITS-1:0] w_next_idx;
    logic [EB-1:0]                     w_axis_ext;
    pln_pkg::t_ctx                     n_f4_ctx;
    logic [SB:0]                       n_f4_mod;

    assign w_span1 = '{big: 1'b0, low: SB'(w_eff[0])};

    always_comb begin
        w_span[0] = '{big: 1'b0, low: SB'(1)};
        w_span[1] = w_span1;
        w_span[2] = r_f3_span2;
        w_span[3] = r_f3_span3;
        w_span[4] = r_f3_span4;

        w_axis     = r_f3_dir[pln_pkg::AXIS_BITS-1:0];
        w_next_idx = pln_pkg::SPAN_IDX_BITS'(w_axis) + pln_pkg::SPAN_IDX_BITS'(1);
        w_axis_ext = w_eff[w_axis];

        n_f4_ctx.site     = r_f3_site;
        n_f4_ctx.backward = r_f3_dir[pln_pkg::DIR_BITS-1];
        n_f4_ctx.stride   = w_span[pln_pkg::SPAN_IDX_BITS'(w_axis)];
        n_f4_ctx.wrap     = pln_pkg::span_scale(n_f4_ctx.stride, w_axis_ext - EB'(1));
        // Past the volume only when the volume is below 2^SB.
        n_f4_ctx.oor      = !r_f3_span4.big && (r_f3_site >= r_f3_span4.low);
        n_f4_mod          = pln_pkg::span_clamp(w_span[w_next_idx]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
            r_f4_v <= 1'b0;
        end else begin
            if (w_en_f0) r_f0_v <= i_valid;
            if (w_en_f1) r_f1_v <= r_f0_v;
            if (w_en_f2) r_f2_v <= r_f1_v;
            if (w_en_f3) r_f3_v <= r_f2_v;
            if (w_en_f4) r_f4_v <= r_f3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_f0) begin
            r_f0_site <= i_site_index;
            r_f0_dir  <= i_direction;
        end
        if (w_en_f1) begin
            r_f1_site  <= r_f0_site;
            r_f1_dir   <= r_f0_dir;
            r_f1_span2 <= pln_pkg::span_scale(w_span1, w_eff[1]);
        end
        if (w_en_f2) begin
            r_f2_site  <= r_f1_site;
            r_f2_dir   <= r_f1_dir;
            r_f2_span2 <= r_f1_span2;
            r_f2_span3 <= pln_pkg::span_scale(r_f1_span2, w_eff[2]);
        end
        if (w_en_f3) begin
            r_f3_site  <= r_f2_site;
            r_f3_dir   <= r_f2_dir;
            r_f3_span2 <= r_f2_span2;
            r_f3_span3 <= r_f2_span3;
            r_f3_span4 <= pln_pkg::span_scale(r_f2_span3, w_eff[3]);
        end
        if (w_en_f4) begin
            r_f4_ctx <= n_f4_ctx;
            r_f4_mod <= n_f4_mod;
        end
    end

    // ------------------------------------------------------ remainder pipeline
    logic          w_rem_valid;
    pln_pkg::t_ctx w_rem_ctx;
    logic [SB-1:0] w_rem;
    logic          w_out_en;

    pln_rem_pipe u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_f4_v),
        .o_ready   (w_rem_ready),
        .i_ctx     (r_f4_ctx),
        .i_modulus (r_f4_mod),
        .o_valid   (w_rem_valid),
        .i_ready   (w_out_en),
        .o_ctx     (w_rem_ctx),
        .o_rem     (w_rem)
    );

    // ---------------------------------------------------------- output stage
    logic          r_out_v;
    logic [SB-1:0] r_out_site;
    logic          r_out_oor;
    logic          w_at_top;
    logic          w_at_zero;
    logic [SB-1:0] n_out_site;

    assign w_out_en = !r_out_v || i_ready;

    always_comb begin
        // Top coordinate: remainder reaches (extent - 1) * stride.
        w_at_top  = !w_rem_ctx.wrap.big && (w_rem >= w_rem_ctx.wrap.low);
        // Zero coordinate: remainder below the stride.
        w_at_zero = w_rem_ctx.stride.big || (w_rem < w_rem_ctx.stride.low);
        if (w_rem_ctx.oor) begin
            n_out_site = '0;
        end else if (w_rem_ctx.backward) begin
            n_out_site = w_at_zero ? (w_rem_ctx.site + w_rem_ctx.wrap.low)
                                   : (w_rem_ctx.site - w_rem_ctx.stride.low);
        end else begin
            n_out_site = w_at_top ? (w_rem_ctx.site - w_rem_ctx.wrap.low)
                                  : (w_rem_ctx.site + w_rem_ctx.stride.low);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_out_en) begin
            r_out_v <= w_rem_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_out_site <= n_out_site;
            r_out_oor  <= w_rem_ctx.oor;
        end
    end

    assign o_valid         = r_out_v;
    assign o_neighbor_site = r_out_site;
    assign o_out_of_range  = r_out_oor;

    // ------------------------------------------------------------ assertions
    a_oor_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_neighbor_site == '0))
        else $error("out-of-range beat with nonzero neighbor");

    a_stride_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f4_v && !r_f4_ctx.stride.big) |-> (r_f4_ctx.stride.low != '0))
        else $error("zero stride selected");

    a_mod_covers_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f4_v && !r_f4_mod[SB]) |-> (!r_f4_ctx.stride.big
            && (r_f4_mod >= {1'b0, r_f4_ctx.stride.low})))
        else $error("modulus below the stride of the stepped axis");

endmodule
